// ===== src/rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared codes and constants of the range frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

    // Input operation codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // Phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEEK   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CORRUPT   = 2'd1;
    localparam logic [1:0] ST_TO_SEEK   = 2'd2;
    localparam logic [1:0] ST_TO_DIGITS = 2'd3;

    // ASCII characters of the frame
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_R    = 8'h52;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;

    // Field widths and limits
    localparam int DIST_W = 14;
    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
    localparam logic [DIST_W-1:0] DIST_MAX      = 14'd9999;

endpackage

// ===== src/range_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// range_frame_parser_top
// ASCII range sensor frame parser: one measurement per start word.
// ----------------------------------------------------------------------------
// Takes one input word per cycle (start, received byte or millisecond tick)
// and answers with at most one result word in the cycle after acceptance,
// held in an output register. A start word gives a result with sensor_enable
// high; the measurement then ends on NUM_DIGITS digits after a CR 'R' frame
// start (not preceded by '.'), on a non-digit in the digit field, or when the
// tick count reaches r_timeout, each with a result that drops sensor_enable.
// Throughput is one word per cycle: the whole update is a single pass of
// logic between the parser state and the output register, and the input
// stays ready while the output register is empty or being drained.
module range_frame_parser_top #(
    parameter int NUM_DIGITS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [rfp_pkg::TICK_W-1:0]   i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_operation,
    input  logic [7:0]                   i_rx_byte,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_done_res,
    output logic [rfp_pkg::DIST_W-1:0]   o_distance,
    output logic [1:0]                   o_status,
    output logic                         o_sensor_enable
);

    localparam int CNT_W = $clog2(NUM_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_DIGITS);

    logic [rfp_pkg::TICK_W-1:0] r_timeout;
    logic [1:0]                 r_phase,  n_phase;
    logic [7:0]                 r_prev,   n_prev;
    logic [7:0]                 r_prev2,  n_prev2;
    logic [CNT_W-1:0]           r_count,  n_count;
    logic [rfp_pkg::DIST_W-1:0] r_acc,    n_acc;
    logic [rfp_pkg::TICK_W-1:0] r_ticks,  n_ticks;

    logic                       r_out_valid;
    logic                       r_done,   n_done;
    logic [rfp_pkg::DIST_W-1:0] r_dist,   n_dist;
    logic [1:0]                 r_status, n_status;
    logic                       r_enable, n_enable;
    logic                       n_emit;

    logic                       accept;
    logic [rfp_pkg::TICK_W-1:0] tick_inc;
    logic                       is_digit;
    logic [rfp_pkg::DIST_W+3:0] acc_mul;
    logic [CNT_W-1:0]           count_inc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Saturating tick count, digit test and next accumulator value
    assign tick_inc  = (r_ticks == rfp_pkg::TICK_MAX) ? r_ticks : r_ticks + 1'b1;
    assign is_digit  = (i_rx_byte >= rfp_pkg::ASCII_ZERO) &&
                       (i_rx_byte <= rfp_pkg::ASCII_NINE);
    assign acc_mul   = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                     + {14'd0, 4'(i_rx_byte - rfp_pkg::ASCII_ZERO)};
    assign count_inc = r_count + 1'b1;

    // Parser update for one word
    always_comb begin
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_prev2  = r_prev2;
        n_count  = r_count;
        n_acc    = r_acc;
        n_ticks  = r_ticks;
        n_emit   = 1'b0;
        n_done   = 1'b1;
        n_dist   = '0;
        n_status = rfp_pkg::ST_OK;
        n_enable = 1'b0;
        if (i_operation == rfp_pkg::OP_START) begin
            n_phase  = rfp_pkg::PH_SEEK;
            n_prev   = rfp_pkg::ASCII_ZERO;
            n_prev2  = rfp_pkg::ASCII_ZERO;
            n_count  = '0;
            n_acc    = '0;
            n_ticks  = '0;
            n_emit   = 1'b1;
            n_done   = 1'b0;
            n_enable = 1'b1;
        end else if (i_operation == rfp_pkg::OP_TICK && r_phase != rfp_pkg::PH_IDLE) begin
            n_ticks = tick_inc;
            if (tick_inc >= r_timeout) begin
                n_phase  = rfp_pkg::PH_IDLE;
                n_emit   = 1'b1;
                n_status = (r_phase == rfp_pkg::PH_SEEK) ? rfp_pkg::ST_TO_SEEK
                                                         : rfp_pkg::ST_TO_DIGITS;
            end
        end else if (i_operation == rfp_pkg::OP_BYTE && r_phase == rfp_pkg::PH_SEEK) begin
            if (i_rx_byte == rfp_pkg::ASCII_R && r_prev == rfp_pkg::ASCII_CR &&
                r_prev2 != rfp_pkg::ASCII_DOT) begin
                n_phase = rfp_pkg::PH_DIGITS;
                n_count = '0;
                n_acc   = '0;
            end else begin
                n_prev2 = r_prev;
                n_prev  = i_rx_byte;
            end
        end else if (i_operation == rfp_pkg::OP_BYTE && r_phase != rfp_pkg::PH_IDLE) begin
            if (is_digit) begin
                n_acc   = acc_mul[rfp_pkg::DIST_W-1:0];
                n_count = count_inc;
                if (count_inc >= CNT_LAST) begin
                    n_phase = rfp_pkg::PH_IDLE;
                    n_emit  = 1'b1;
                    n_dist  = acc_mul[rfp_pkg::DIST_W-1:0];
                end
            end else begin
                n_acc    = '0;
                n_phase  = rfp_pkg::PH_IDLE;
                n_emit   = 1'b1;
                n_status = rfp_pkg::ST_CORRUPT;
            end
        end
    end

    // Hold configuration and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= rfp_pkg::TIMEOUT_RESET;
            r_phase   <= rfp_pkg::PH_IDLE;
            r_prev    <= rfp_pkg::ASCII_ZERO;
            r_prev2   <= rfp_pkg::ASCII_ZERO;
            r_count   <= '0;
            r_acc     <= '0;
            r_ticks   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_prev  <= n_prev;
                r_prev2 <= n_prev2;
                r_count <= n_count;
                r_acc   <= n_acc;
                r_ticks <= n_ticks;
            end
        end
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_done   <= n_done;
            r_dist   <= n_dist;
            r_status <= n_status;
            r_enable <= n_enable;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_done_res      = r_done;
    assign o_distance      = r_dist;
    assign o_status        = r_status;
    assign o_sensor_enable = r_enable;

endmodule

// ===== src/rfp_checker.sv =====
// ----------------------------------------------------------------------------
// rfp_checker
// Port-level assertions for the range frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module rfp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_done_res,
    input logic [rfp_pkg::DIST_W-1:0] o_distance,
    input logic [1:0]                 o_status,
    input logic                       o_sensor_enable
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid &&
        $stable({o_done_res, o_distance, o_status, o_sensor_enable}))
        else $error("stalled result word changed");

    // Never stall the input while the output register is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with empty output register");

    // Block an offered word while a result word waits
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted over a stalled result word");

    // Start word powers the sensor with a clean result
    a_start_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |->
        o_sensor_enable && o_distance == '0 && o_status == rfp_pkg::ST_OK)
        else $error("bad start result word");

    // Ending word drops the enable and stays within DIST_MAX; errors carry zero distance
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_sensor_enable &&
        (o_status == rfp_pkg::ST_OK || o_distance == '0) &&
        o_distance <= rfp_pkg::DIST_MAX)
        else $error("bad end result word");

endmodule

bind range_frame_parser_top rfp_checker u_rfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_done_res      (o_done_res),
    .o_distance      (o_distance),
    .o_status        (o_status),
    .o_sensor_enable (o_sensor_enable)
);
